FILE: sv/three_step_pulse_interval_map_core_macros.svh
// Assertion macros for the three-step interval map core.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef THREE_STEP_PULSE_INTERVAL_MAP_CORE_MACROS_SVH
`define THREE_STEP_PULSE_INTERVAL_MAP_CORE_MACROS_SVH

// same-cycle implication
`define TSPIM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tspim check failed");

// next-cycle implication
`define TSPIM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tspim check failed");

`endif

FILE: sv/tspim_pkg.sv
// Shared constants and codes for the three-step interval map core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tspim_pkg;
	localparam int FIELD_W = 32;
	localparam int WORD_BITS_DEF = 32;
	// shoulder weight is height/4, center band is span/2
	localparam int MED_DIV_SHIFT = 2;
	localparam int MAX_DIV_SHIFT = 1;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;
endpackage
`default_nettype wire

FILE: sv/tspim_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a sideband word and a valid bit alongside; no package use.
`timescale 1ns / 1ps
`default_nettype none
module tspim_div #(
	parameter int W  = 32,
	parameter int NB = 32,
	parameter int SW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [NB-1:0] dividend,
	input  wire logic [W-1:0]  divisor,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic [NB-1:0]      quo,
	output logic [W-1:0]       rem,
	output logic [SW-1:0]      side_out
);
	logic          vld_s [1:NB];
	logic [W-1:0]  rem_s [1:NB];
	logic [W-1:0]  dv_s  [1:NB];
	logic [NB-1:0] num_s [1:NB];
	logic [NB-1:0] quo_s [1:NB];
	logic [SW-1:0] sd_s  [1:NB];

	genvar i;
	for (i = 1; i <= NB; i++) begin : g_st
		logic          pv;
		logic [W-1:0]  pr;
		logic [W-1:0]  pdv;
		logic [NB-1:0] pn;
		logic [NB-1:0] pq;
		logic [SW-1:0] psd;
		logic [W:0]    trial;
		logic          ge;

		if (i == 1) begin : g_first
			assign pv  = in_valid;
			assign pr  = '0;
			assign pdv = divisor;
			assign pn  = dividend;
			assign pq  = '0;
			assign psd = side_in;
		end else begin : g_next
			assign pv  = vld_s[i-1];
			assign pr  = rem_s[i-1];
			assign pdv = dv_s[i-1];
			assign pn  = num_s[i-1];
			assign pq  = quo_s[i-1];
			assign psd = sd_s[i-1];
		end

		assign trial = {pr, pn[NB-1]};
		assign ge    = trial >= {1'b0, pdv};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? W'(trial - {1'b0, pdv}) : trial[W-1:0];
				dv_s[i]  <= pdv;
				num_s[i] <= pn << 1;
				quo_s[i] <= {pq[NB-2:0], ge};
				sd_s[i]  <= psd;
			end
		end
	end

	assign out_valid = vld_s[NB];
	assign quo       = quo_s[NB];
	assign rem       = rem_s[NB];
	assign side_out  = sd_s[NB];
endmodule
`default_nettype wire

FILE: sv/three_step_pulse_interval_map_core.sv
// Three-step pulse interval map core: frequency model of a range coder.
// Uses tspim_pkg, tspim_div and the assertion macro header.
//
// Usage:
//   Input channel item_valid/item_stall carries opcode, item, window_left,
//   window_right, peak_weight and range_top. Output channel
//   result_valid/result_stall returns total, low_cum, sym_weight, value_out
//   and hit. One result per input beat, in order.
//   Opcode encode maps a value to its coding interval; opcode decode maps a
//   cumulative count to the value and the low edge of its interval.
//   Two bit-serial divider pipelines lie on the path from accepted beat
//   to result_valid: one WORD_BITS+1 deep for the height clamp, one
//   WORD_BITS deep for the decode quotient.
//   Throughput: one beat per cycle while the output is not stalled.
//   Reset clears every stage valid bit; the pipe comes up empty.
//   A stall on the output while result_valid is high freezes the whole
//   pipe; item_stall rises in the same cycle, so no beat is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "three_step_pulse_interval_map_core_macros.svh"
module three_step_pulse_interval_map_core #(
	parameter int WORD_BITS = tspim_pkg::WORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire logic                         opcode,
	input  wire logic [tspim_pkg::FIELD_W-1:0] item,
	input  wire logic [tspim_pkg::FIELD_W-1:0] window_left,
	input  wire logic [tspim_pkg::FIELD_W-1:0] window_right,
	input  wire logic [tspim_pkg::FIELD_W-1:0] peak_weight,
	input  wire logic [tspim_pkg::FIELD_W-1:0] range_top,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic [tspim_pkg::FIELD_W-1:0]     total,
	output logic [tspim_pkg::FIELD_W-1:0]     low_cum,
	output logic [tspim_pkg::FIELD_W-1:0]     sym_weight,
	output logic [tspim_pkg::FIELD_W-1:0]     value_out,
	output logic                              hit
);
	localparam int W = WORD_BITS;

	typedef logic [W-1:0] word_t;

	typedef struct packed {
		logic  op;
		word_t item;
		word_t left;
		word_t right;
		word_t range;
		word_t h0;
		word_t d;
		logic  big;
	} clamp_side_t;

	typedef struct packed {
		logic  op;
		word_t tot;
		word_t base;
		word_t prod;
		word_t sym;
		logic  hit;
		word_t item;
	} div_side_t;

	logic en;
	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;

	// s1: input capture
	logic  v_s1, op_s1;
	word_t item_s1, left_s1, right_s1, peak_s1, range_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= opcode;
			item_s1  <= item[W-1:0];
			left_s1  <= window_left[W-1:0];
			right_s1 <= window_right[W-1:0];
			peak_s1  <= peak_weight[W-1:0];
			range_s1 <= range_top[W-1:0];
		end
	end

	// s2: height * (right-left) for the clamp test
	word_t          d_c, h0_c;
	logic  [2*W-1:0] hd_s2;
	clamp_side_t    c_s2;
	logic           v_s2;

	assign d_c  = right_s1 - left_s1;
	assign h0_c = (peak_s1 == '0) ? word_t'(1) : peak_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hd_s2   <= h0_c * d_c;
			c_s2.op    <= op_s1;
			c_s2.item  <= item_s1;
			c_s2.left  <= left_s1;
			c_s2.right <= right_s1;
			c_s2.range <= range_s1;
			c_s2.h0    <= h0_c;
			c_s2.d     <= d_c;
			c_s2.big   <= 1'b0;
		end
	end

	clamp_side_t c_in, c_out;
	logic        v_d1;
	logic [W:0]  q_d1;
	word_t       r_d1;

	always_comb begin
		c_in     = c_s2;
		c_in.big = (hd_s2[2*W-1:W] != '0) && (c_s2.d != '0);
	end

	// 2^W / d
	tspim_div #(.W(W), .NB(W + 1), .SW($bits(clamp_side_t))) u_clamp_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.dividend ({1'b1, {W{1'b0}}}),
		.divisor  (c_s2.d),
		.side_in  (c_in),
		.out_valid(v_d1),
		.quo      (q_d1),
		.rem      (r_d1),
		.side_out (c_out)
	);

	// s3: clamped height and band sizes
	word_t h_c1, h_c, span_c, maxh_c, medd_c, mh_c;
	logic  v_s3, op_s3;
	word_t item_s3, left_s3, right_s3, range_s3, h_s3, mh_s3, medd_s3, maxd_s3;

	always_comb begin
		h_c1   = c_out.big ? q_d1[W-1:0] : c_out.h0;
		h_c    = (h_c1 == '0) ? word_t'(1) : h_c1;
		span_c = c_out.d + word_t'(1);
		maxh_c = span_c >> tspim_pkg::MAX_DIV_SHIFT;
		medd_c = (span_c - maxh_c) >> 1;
		mh_c   = ((h_c >> tspim_pkg::MED_DIV_SHIFT) == '0) ? word_t'(1)
			: (h_c >> tspim_pkg::MED_DIV_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3    <= c_out.op;
			item_s3  <= c_out.item;
			left_s3  <= c_out.left;
			right_s3 <= c_out.right;
			range_s3 <= c_out.range;
			h_s3     <= h_c;
			mh_s3    <= mh_c;
			medd_s3  <= medd_c;
			maxd_s3  <= span_c - (medd_c << 1);
		end
	end

	// s4: band weights
	logic  v_s4, op_s4;
	word_t item_s4, left_s4, right_s4, range_s4, h_s4, mh_s4, medd_s4, maxd_s4;
	word_t medw_s4, maxw_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s4    <= op_s3;
			item_s4  <= item_s3;
			left_s4  <= left_s3;
			right_s4 <= right_s3;
			range_s4 <= range_s3;
			h_s4     <= h_s3;
			mh_s4    <= mh_s3;
			medd_s4  <= medd_s3;
			maxd_s4  <= maxd_s3;
			medw_s4  <= word_t'(medd_s3 * mh_s3);
			maxw_s4  <= word_t'(maxd_s3 * h_s3);
		end
	end

	// s5: first cumulative edges
	logic  v_s5, op_s5;
	word_t item_s5, left_s5, right_s5, h_s5, mh_s5, medd_s5, maxd_s5, medw_s5;
	word_t t1_s5, t2_s5, rr_s5, lm_s5, rm_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s5    <= op_s4;
			item_s5  <= item_s4;
			left_s5  <= left_s4;
			right_s5 <= right_s4;
			h_s5     <= h_s4;
			mh_s5    <= mh_s4;
			medd_s5  <= medd_s4;
			maxd_s5  <= maxd_s4;
			medw_s5  <= medw_s4;
			t1_s5    <= left_s4 + medw_s4;
			t2_s5    <= left_s4 + medw_s4 + maxw_s4;
			rr_s5    <= range_s4 - right_s4 - word_t'(1);
			lm_s5    <= left_s4 + medd_s4;
			rm_s5    <= right_s4 - medd_s4;
		end
	end

	// s6: upper edge and total
	logic  v_s6, op_s6;
	word_t item_s6, left_s6, right_s6, h_s6, mh_s6, medd_s6;
	word_t t1_s6, t2_s6, t3_s6, tot_s6, lm_s6, rm_s6, lmm_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s6    <= op_s5;
			item_s6  <= item_s5;
			left_s6  <= left_s5;
			right_s6 <= right_s5;
			h_s6     <= h_s5;
			mh_s6    <= mh_s5;
			medd_s6  <= medd_s5;
			t1_s6    <= t1_s5;
			t2_s6    <= t2_s5;
			t3_s6    <= t2_s5 + medw_s5;
			tot_s6   <= t2_s5 + medw_s5 + rr_s5;
			lm_s6    <= lm_s5;
			rm_s6    <= rm_s5;
			lmm_s6   <= lm_s5 + maxd_s5;
		end
	end

	// s7: band select; encode low = base + a*b, decode splits off/dv
	word_t a_c, b_c, base_c, sym_c, off_c, dv_c;
	logic  hit_c;

	always_comb begin
		a_c    = '0;
		b_c    = word_t'(1);
		base_c = '0;
		sym_c  = word_t'(1);
		off_c  = '0;
		dv_c   = word_t'(1);
		hit_c  = 1'b0;
		case (tspim_pkg::op_t'(op_s6))
			tspim_pkg::OP_ENCODE: begin
				if (item_s6 >= left_s6 && item_s6 <= right_s6) begin
					hit_c = 1'b1;
					if (item_s6 < lm_s6) begin
						a_c    = item_s6 - left_s6;
						b_c    = mh_s6;
						base_c = left_s6;
						sym_c  = mh_s6;
					end else if (item_s6 > rm_s6) begin
						a_c    = item_s6 - right_s6 + medd_s6 - word_t'(1);
						b_c    = mh_s6;
						base_c = t2_s6;
						sym_c  = mh_s6;
					end else begin
						a_c    = item_s6 - left_s6 - medd_s6;
						b_c    = h_s6;
						base_c = t1_s6;
						sym_c  = h_s6;
					end
				end else if (item_s6 > right_s6) begin
					a_c    = item_s6 - right_s6 - word_t'(1);
					base_c = t3_s6;
				end else begin
					a_c = item_s6;
				end
			end
			tspim_pkg::OP_DECODE: begin
				// base holds the value offset of the band
				if (item_s6 < left_s6) begin
					base_c = item_s6;
				end else if (item_s6 < t1_s6) begin
					hit_c  = 1'b1;
					off_c  = item_s6 - left_s6;
					dv_c   = mh_s6;
					sym_c  = mh_s6;
					base_c = left_s6;
				end else if (item_s6 < t2_s6) begin
					hit_c  = 1'b1;
					off_c  = item_s6 - t1_s6;
					dv_c   = h_s6;
					sym_c  = h_s6;
					base_c = lm_s6;
				end else if (item_s6 < t3_s6) begin
					hit_c  = 1'b1;
					off_c  = item_s6 - t2_s6;
					dv_c   = mh_s6;
					sym_c  = mh_s6;
					base_c = lmm_s6;
				end else begin
					base_c = right_s6 + word_t'(1) + item_s6 - t3_s6;
				end
			end
			default: begin
				a_c = item_s6;
			end
		endcase
	end

	logic  v_s7;
	word_t a_s7, b_s7, off_s7, dv_s7;
	div_side_t sd_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s7        <= a_c;
			b_s7        <= b_c;
			off_s7      <= off_c;
			dv_s7       <= dv_c;
			sd_s7.op    <= op_s6;
			sd_s7.tot   <= tot_s6;
			sd_s7.base  <= base_c;
			sd_s7.prod  <= '0;
			sd_s7.sym   <= sym_c;
			sd_s7.hit   <= hit_c;
			sd_s7.item  <= item_s6;
		end
	end

	// s8: encode product
	logic  v_s8;
	word_t off_s8, dv_s8;
	div_side_t sd_s8, sd_c8;

	always_comb begin
		sd_c8      = sd_s7;
		sd_c8.prod = word_t'(a_s7 * b_s7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_s8 <= off_s7;
			dv_s8  <= dv_s7;
			sd_s8  <= sd_c8;
		end
	end

	div_side_t sd_d2;
	logic      v_d2;
	word_t     q_d2, r_d2;

	tspim_div #(.W(W), .NB(W), .SW($bits(div_side_t))) u_band_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s8),
		.dividend (off_s8),
		.divisor  (dv_s8),
		.side_in  (sd_s8),
		.out_valid(v_d2),
		.quo      (q_d2),
		.rem      (r_d2),
		.side_out (sd_d2)
	);

	// s9: output register
	logic  v_s9, hit_s9;
	word_t tot_s9, low_s9, sym_s9, val_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tot_s9 <= sd_d2.tot;
			sym_s9 <= sd_d2.sym;
			hit_s9 <= sd_d2.hit;
			if (sd_d2.op == tspim_pkg::OP_DECODE) begin
				low_s9 <= sd_d2.item - r_d2;
				val_s9 <= sd_d2.base + q_d2;
			end else begin
				low_s9 <= sd_d2.base + sd_d2.prod;
				val_s9 <= sd_d2.item;
			end
		end
	end

	assign result_valid = v_s9;
	assign total        = tspim_pkg::FIELD_W'(tot_s9);
	assign low_cum      = tspim_pkg::FIELD_W'(low_s9);
	assign sym_weight   = tspim_pkg::FIELD_W'(sym_s9);
	assign value_out    = tspim_pkg::FIELD_W'(val_s9);
	assign hit          = hit_s9;

	`TSPIM_ASSERT_NOW(a_sym_nonzero, result_valid, sym_s9 != '0)
	`TSPIM_ASSERT_NOW(a_miss_unit, result_valid && !hit_s9, sym_s9 == word_t'(1))
	`TSPIM_ASSERT_NEXT(a_pipe_frozen, item_stall, $stable(v_s1) && $stable(v_s8))
endmodule
`default_nettype wire
